>>> design/rled_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rled_pkg: shared types and codes of the range list entry decoder
// Holds the payload structs of both channels, the entry status codes, the
// DWARF 5 range list kind codes and the records passed between the parts.
// ----------------------------------------------------------------------------
package rled_pkg;

  // Entry status codes on the result channel.
  localparam logic [1:0] ST_RANGE   = 2'd0;
  localparam logic [1:0] ST_END     = 2'd1;
  localparam logic [1:0] ST_INDEXED = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  // Range list entry kinds that carry operands.
  localparam logic [2:0] KIND_OFFSET_PAIR  = 3'd4;
  localparam logic [2:0] KIND_BASE_ADDRESS = 3'd5;
  localparam logic [2:0] KIND_START_END    = 3'd6;
  localparam logic [2:0] KIND_START_LENGTH = 3'd7;

  // Raw kind bytes that bound the classes.
  localparam logic [7:0] BYTE_END_OF_LIST   = 8'd0;
  localparam logic [7:0] BYTE_LAST_INDEXED  = 8'd3;
  localparam logic [7:0] BYTE_LAST_KNOWN    = 8'd7;

  // Operand byte limits.
  localparam logic [3:0] ULEB_MAX_BYTES = 4'd10;
  localparam logic [3:0] ADDR_BYTES     = 4'd8;

  // Configuration register index (byte address bit 3).
  localparam logic CFG_UNIT_BASE = 1'b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       list_start;
  } in_item_t;

  typedef struct packed {
    logic [63:0] range_low;
    logic [63:0] range_high;
    logic [1:0]  entry_status;
  } out_item_t;

  // A byte after classification: cls is the status a kind byte would report,
  // ST_RANGE where it names an entry with operands.
  typedef struct packed {
    logic [1:0] cls;
    logic       list_start;
    logic [7:0] data_byte;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Parser phases, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_KIND = 4'b0010,
    PH_OP1  = 4'b0100,
    PH_OP2  = 4'b1000
  } phase_t;

endpackage : rled_pkg
`default_nettype wire

>>> design/range_list_entry_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// range_list_entry_decoder_core: DWARF 5 range list entry decoder
// Decodes a range list section body one byte per transfer into address ranges
// and end-of-list or error reports.
//
//   Channel  Direction  Payload                              Handshake
//   in_      input      data_byte, list_start                valid/ready
//   out_     output     range_low, range_high, entry_status  valid/ready
//   cfg      input      unit_base_address at byte address 0  APB, pready=1
//
// One byte is taken per cycle while the queue has room; the parser step
// (operand placement and one 64-bit add) sets that figure. A two-entry queue
// lets intake continue while the result register waits. Reset clears all
// parser state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module range_list_entry_decoder_core (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire rled_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output rled_pkg::out_item_t      out_data,
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire  [3:0]               paddr,
  input  wire  [63:0]              pwdata,
  output logic [63:0]              prdata,
  output logic                     pready
);
  import rled_pkg::*;

  logic [63:0] unit_base_r;
  q_push_t     q_push;
  q_status_t   q_status;
  q_item_t     head;
  logic        pop;
  logic        cfg_wr;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[3] == CFG_UNIT_BASE);
  assign prdata = (paddr[3] == CFG_UNIT_BASE) ? unit_base_r : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_base_r <= 64'd0;
    end else if (cfg_wr) begin
      unit_base_r <= pwdata;
    end
  end

  rled_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .q_push   (q_push)
  );

  rled_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .pop      (pop),
    .q_status (q_status),
    .head     (head)
  );

  rled_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .unit_base (unit_base_r),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule : range_list_entry_decoder_core
`default_nettype wire

>>> design/rled_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rled_front: byte intake and kind classification
// Takes section bytes while the queue has room and tags each one with the
// class it would have as a kind byte.
// ----------------------------------------------------------------------------
module rled_front (
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire rled_pkg::in_item_t  in_data,
  input  wire rled_pkg::q_status_t q_status,
  output rled_pkg::q_push_t        q_push
);
  import rled_pkg::*;

  logic [1:0] cls;

  // Classify the byte as a kind code.
  always_comb begin
    priority if (in_data.data_byte == BYTE_END_OF_LIST) begin
      cls = ST_END;
    end else if (in_data.data_byte <= BYTE_LAST_INDEXED) begin
      cls = ST_INDEXED;
    end else if (in_data.data_byte > BYTE_LAST_KNOWN) begin
      cls = ST_UNKNOWN;
    end else begin
      cls = ST_RANGE;
    end
  end

  // A transfer is taken whenever the queue has a free slot.
  assign in_ready                 = !q_status.full;
  assign q_push.valid             = in_valid && !q_status.full;
  assign q_push.item.cls          = cls;
  assign q_push.item.list_start   = in_data.list_start;
  assign q_push.item.data_byte    = in_data.data_byte;

endmodule : rled_front
`default_nettype wire

>>> design/rled_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rled_queue: two-entry queue between intake and parser
// Lets the intake side keep taking bytes while the parser waits on the
// result channel, and the reverse.
// ----------------------------------------------------------------------------
module rled_queue (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire rled_pkg::q_push_t   q_push,
  input  wire                      pop,
  output rled_pkg::q_status_t      q_status,
  output rled_pkg::q_item_t        head
);
  import rled_pkg::*;

  q_item_t    slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign q_status.full  = (count_r == 2'd2);
  assign q_status.empty = (count_r == 2'd0);
  assign do_pop         = pop && !q_status.empty;
  assign head           = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = q_push.valid ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, q_push.valid} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      slot_r[wr_ptr_r] <= q_push.item;
    end
  end

endmodule : rled_queue
`default_nettype wire

>>> design/rled_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rled_back: entry parser and result register
// Consumes one classified byte per cycle unless stalled, builds ULEB128 and
// 8-byte operands, tracks the base address and drives the result register.
// ----------------------------------------------------------------------------
module rled_back (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire  [63:0]              unit_base,
  input  wire rled_pkg::q_status_t q_status,
  input  wire rled_pkg::q_item_t   head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire                      out_ready,
  output rled_pkg::out_item_t      out_data
);
  import rled_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] base_r, base_nxt;
  logic [63:0] pend_r, pend_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  // State as seen by this byte, after a list start has reloaded it.
  phase_t      ph_e;
  logic [2:0]  kind_e;
  logic [3:0]  cnt_e;
  logic [63:0] acc_e, base_e, pend_e;

  logic        is_uleb, done, emit;
  logic [5:0]  uleb_sh;
  logic [5:0]  addr_sh;
  logic [63:0] acc_new, addend, sum;

  // A byte is consumed when the result register is free or being emptied.
  assign pop = !q_status.empty && (!out_valid_r || out_ready);

  always_comb begin
    ph_e   = head.list_start ? PH_KIND : phase_r;
    kind_e = head.list_start ? 3'd0 : kind_r;
    cnt_e  = head.list_start ? 4'd0 : cnt_r;
    acc_e  = head.list_start ? 64'd0 : acc_r;
    base_e = head.list_start ? unit_base : base_r;
    pend_e = head.list_start ? 64'd0 : pend_r;
  end

  // Operand byte placement: 7 bits per ULEB128 byte, 8 per address byte.
  always_comb begin
    is_uleb = (kind_e == KIND_OFFSET_PAIR) ||
              ((kind_e == KIND_START_LENGTH) && (ph_e == PH_OP2));
    uleb_sh = 6'(({3'd0, cnt_e} << 3) - {3'd0, cnt_e});
    addr_sh = {cnt_e[2:0], 3'd0};
    if (is_uleb) begin
      if (cnt_e < ULEB_MAX_BYTES) begin
        acc_new = acc_e | ({57'd0, head.data_byte[6:0]} << uleb_sh);
        cnt_nxt = cnt_e + 4'd1;
      end else begin
        acc_new = acc_e;
        cnt_nxt = cnt_e;
      end
      done = !head.data_byte[7];
    end else begin
      acc_new = acc_e | ({56'd0, head.data_byte} << addr_sh);
      cnt_nxt = cnt_e + 4'd1;
      done    = (cnt_nxt >= ADDR_BYTES);
    end
  end

  // One shared adder: base plus offset, or start plus length.
  assign addend = (kind_e == KIND_OFFSET_PAIR) ? base_e : pend_e;
  assign sum    = addend + acc_new;

  // Parser step for the byte at the queue head.
  always_comb begin
    phase_nxt    = ph_e;
    kind_nxt     = kind_e;
    acc_nxt      = acc_new;
    base_nxt     = base_e;
    pend_nxt     = pend_e;
    emit         = 1'b0;
    out_item_nxt = '{range_low: 64'd0, range_high: 64'd0, entry_status: ST_RANGE};
    unique case (ph_e)
      PH_IDLE: begin
        acc_nxt = acc_e;
      end
      PH_KIND: begin
        acc_nxt = 64'd0;
        if (head.cls != ST_RANGE) begin
          phase_nxt                 = PH_IDLE;
          emit                      = 1'b1;
          out_item_nxt.entry_status = head.cls;
        end else begin
          kind_nxt  = head.data_byte[2:0];
          phase_nxt = PH_OP1;
        end
      end
      PH_OP1, PH_OP2: begin
        if (done) begin
          acc_nxt = 64'd0;
          priority if (kind_e == KIND_BASE_ADDRESS) begin
            base_nxt  = acc_new;
            phase_nxt = PH_KIND;
          end else if (ph_e == PH_OP1) begin
            pend_nxt  = (kind_e == KIND_OFFSET_PAIR) ? sum : acc_new;
            phase_nxt = PH_OP2;
          end else begin
            phase_nxt               = PH_KIND;
            emit                    = 1'b1;
            out_item_nxt.range_low  = pend_e;
            out_item_nxt.range_high = (kind_e == KIND_START_END) ? acc_new : sum;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Result register valid bit.
  always_comb begin
    if (pop) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      kind_r      <= 3'd0;
      cnt_r       <= 4'd0;
      acc_r       <= 64'd0;
      base_r      <= 64'd0;
      pend_r      <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r <= phase_nxt;
        kind_r  <= kind_nxt;
        cnt_r   <= done ? 4'd0 : ((ph_e == PH_KIND) ? 4'd0 : cnt_nxt);
        acc_r   <= acc_nxt;
        base_r  <= base_nxt;
        pend_r  <= pend_nxt;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule : rled_back
`default_nettype wire

>>> design/rled_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rled_checker: port-level checks of the range list entry decoder
// Watches the result channel and the configuration port of the top level.
// ----------------------------------------------------------------------------
module rled_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire rled_pkg::out_item_t out_data,
  input wire                      pready
);
  import rled_pkg::*;

  // No result is offered right after a reset cycle.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Status reports carry zero addresses.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.entry_status != ST_RANGE) |->
      (out_data.range_low == 64'd0) && (out_data.range_high == 64'd0))
    else $error("status report with nonzero addresses");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule : rled_checker

bind range_list_entry_decoder_core rled_checker u_rled_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);
`default_nettype wire
